// ===== hdl/dnle_pkg.sv =====
// Shared types and constants of the DNS name label encoder.
package dnle_pkg;

  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2E;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  // One encoded byte handed from the sequencer to the output register.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              flag;
  } emit_t;

endpackage

// ===== hdl/dnle_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dnle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dnle_ctrl.sv =====
// Sequencer: buffers label characters, replays each label with its length and ends each name with a zero byte.
module dnle_ctrl
  import dnle_pkg::*;
#(
  parameter int unsigned MAX_LABEL = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] char_byte_i,
  input  logic              end_of_name_i,
  input  logic              slot_free_i,
  output emit_t             emit_o
);

  localparam int unsigned AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int unsigned CW = $clog2(MAX_LABEL + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LABEL);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LEN  = 4'b0010,
    S_DATA = 4'b0100,
    S_TERM = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          ovf_q, ovf_d;
  logic          end_q, end_d;

  logic              we;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [BYTE_W-1:0] rdata;
  logic              accept;
  logic              is_dot;

  dnle_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_LABEL)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(char_byte_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_dot     = end_of_name_i || (char_byte_i == DOT_CHAR);
  assign we         = accept && !is_dot && (cnt_q < CNT_MAX);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    ovf_d   = ovf_q;
    end_d   = end_q;
    re      = 1'b0;
    raddr   = idx_q;
    emit_o  = '{valid: 1'b0, data: ZERO_BYTE, last: 1'b0, flag: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_dot) begin
            end_d   = end_of_name_i;
            state_d = S_LEN;
          end else if (cnt_q < CNT_MAX) begin
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      S_LEN: begin
        if (slot_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.data  = BYTE_W'(cnt_q);
          if (cnt_q == '0) begin
            state_d = end_q ? S_TERM : S_IDLE;
          end else begin
            // prefetch the first character
            re      = 1'b1;
            raddr   = '0;
            idx_d   = '0;
            state_d = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (slot_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.data  = rdata;
          if (CW'(idx_q) == cnt_q - CW'(1)) begin
            cnt_d   = '0;
            state_d = end_q ? S_TERM : S_IDLE;
          end else begin
            re      = 1'b1;
            raddr   = idx_q + AW'(1);
            idx_d   = idx_q + AW'(1);
          end
        end
      end
      S_TERM: begin
        if (slot_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.data  = ZERO_BYTE;
          emit_o.last  = 1'b1;
          emit_o.flag  = ovf_q;
          ovf_d        = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      ovf_q   <= ovf_d;
      end_q   <= end_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("label count above limit");

  a_data_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA) |-> (cnt_q != '0) && (CW'(idx_q) < cnt_q))
    else $error("replay index outside buffered label");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid |-> slot_free_i)
    else $error("byte emitted into a busy output register");

  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TERM && slot_free_i) |=> !ovf_q && (state_q == S_IDLE))
    else $error("terminator did not clear overflow flag");

endmodule

// ===== hdl/dns_name_label_encoder_unit.sv =====
// Top level of the DNS name label encoder with its output register.
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_ready_o   char_byte_i, end_of_name_i
//   out      output     out_valid_o/out_ready_i out_byte_o, is_last_o, too_long_o
//
// An ordinary character is written to the label RAM while the label has room.
// A dot emits the length byte and the buffered characters, the end item also a zero
// byte; the replay reads one RAM entry per cycle unless stalled, one read prefetched.
// No input is taken during a replay; the next item is taken while the last byte waits.
// Reset clears the count, the overflow flag and the sequencer; the RAM needs no clearing.
// A stall on the output holds the replay with the RAM read data held.
module dns_name_label_encoder_unit
  import dnle_pkg::*;
#(
  parameter int unsigned MAX_LABEL = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] char_byte_i,
  input  logic              end_of_name_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              is_last_o,
  output logic              too_long_o
);

  emit_t             emit;
  logic              slot_free;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              is_last_q;
  logic              too_long_q;

  assign slot_free = !out_valid_q || out_ready_i;

  dnle_ctrl #(
    .MAX_LABEL(MAX_LABEL)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_byte_i  (char_byte_i),
    .end_of_name_i(end_of_name_i),
    .slot_free_i  (slot_free),
    .emit_o       (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload loads on every emitted byte, holds while the transfer stalls
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_byte_q <= emit.data;
      is_last_q  <= emit.last;
      too_long_q <= emit.flag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_last_o   = is_last_q;
  assign too_long_o  = too_long_q;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the DNS name label encoder: random and directed names checked against a predictor.
`timescale 1ns / 100ps

module tb_top
  import dnle_pkg::*;
();

  localparam int unsigned LBL_MAX     = 32;
  localparam int unsigned RAND_ITEMS  = 150;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // One encoded byte on the output channel.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              flag;
  } wire_byte_t;

  // Predicts the wire-format bytes of each name and checks the block's output against them.
  class dns_wire_scoreboard;
    logic [BYTE_W-1:0] label_buf[LBL_MAX];
    int unsigned       label_len;
    int unsigned       raw_len;
    bit                dropped_char;
    wire_byte_t        wire_q[$];
    int unsigned       inputs_seen;
    int unsigned       results_seen;
    int unsigned       mismatches;
    int unsigned       names_done;
    int unsigned       long_names;
    int unsigned       longest_label;

    function new();
      label_len     = 0;
      raw_len       = 0;
      dropped_char  = 1'b0;
      inputs_seen   = 0;
      results_seen  = 0;
      mismatches    = 0;
      names_done    = 0;
      long_names    = 0;
      longest_label = 0;
    endfunction

    function int unsigned pending();
      return wire_q.size();
    endfunction

    // Queue the length byte and the buffered characters, then empty the label.
    function void close_label();
      wire_byte_t wb;
      wb = '{data: BYTE_W'(label_len), last: 1'b0, flag: 1'b0};
      wire_q.push_back(wb);
      for (int unsigned j = 0; j < label_len; j++) begin
        wb = '{data: label_buf[j], last: 1'b0, flag: 1'b0};
        wire_q.push_back(wb);
      end
      if (raw_len > longest_label) longest_label = raw_len;
      label_len = 0;
      raw_len   = 0;
    endfunction

    function void note_input(logic [BYTE_W-1:0] ch, logic eon);
      wire_byte_t wb;
      inputs_seen++;
      if (eon) begin
        close_label();
        wb = '{data: ZERO_BYTE, last: 1'b1, flag: dropped_char};
        wire_q.push_back(wb);
        if (dropped_char) long_names++;
        dropped_char = 1'b0;
        names_done++;
      end else if (ch == DOT_CHAR) begin
        close_label();
      end else begin
        raw_len++;
        if (label_len < LBL_MAX) begin
          label_buf[label_len] = ch;
          label_len++;
        end else begin
          dropped_char = 1'b1;
        end
      end
    endfunction

    function void check_result(logic [BYTE_W-1:0] b, logic last, logic flag);
      wire_byte_t exp_b;
      results_seen++;
      if (wire_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output byte %02h last %b flag %b", b, last, flag);
        return;
      end
      exp_b = wire_q.pop_front();
      if (exp_b.data !== b || exp_b.last !== last || exp_b.flag !== flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at output %0d: exp byte %02h last %b flag %b, got %02h last %b flag %b",
                   results_seen, exp_b.data, exp_b.last, exp_b.flag, b, last, flag);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] char_byte = '0;
  logic              end_of_name = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              is_last;
  logic              too_long;

  dns_wire_scoreboard sb = new();

  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;
  int          tx_calm = 0;
  int          rx_calm = 0;
  bit          hold_done = 1'b0;

  dns_name_label_encoder_unit #(
    .MAX_LABEL(LBL_MAX)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .char_byte_i  (char_byte),
    .end_of_name_i(end_of_name),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte),
    .is_last_o    (is_last),
    .too_long_o   (too_long)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_input(char_byte, end_of_name);
      if (out_valid && out_ready) sb.check_result(out_byte, is_last, too_long);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d bytes still expected", cycle_cnt, sb.pending());
    $display("== FAIL ==");
    $finish;
  end

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = 25;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_label_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 75) return $urandom_range(1, 6);
    if (r < 92) return $urandom_range(7, 20);
    return $urandom_range(28, 40);
  endfunction

  task automatic send_item(input logic [BYTE_W-1:0] ch, input logic eon);
    int n;
    @(negedge clk);
    in_valid    <= 1'b1;
    char_byte   <= ch;
    end_of_name <= eon;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    n = pick_gap(tx_calm);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_label(input int len);
    logic [BYTE_W-1:0] ch;
    for (int i = 0; i < len; i++) begin
      do ch = BYTE_W'($urandom_range(0, 255)); while (ch == DOT_CHAR);
      send_item(ch, 1'b0);
    end
  endtask

  // Drop valid first so the last transfer is not offered again while waiting.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: random ready pattern with one long hold-off once traffic is flowing.
  initial begin : sink
    int n;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && sb.inputs_seen >= 40) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        n = $urandom_range(1, 12);
        repeat (n) begin
          @(negedge clk);
          out_ready <= 1'b1;
        end
        n = pick_gap(rx_calm);
        repeat (n) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
    end
  end

  initial begin : stim
    int  nlab;
    int  name_idx;
    int  base;
    int  n;
    bit  drain_done;
    drain_done = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Empty name; the character on the end item is ignored even when it is a dot.
    send_item(DOT_CHAR, 1'b1);
    // Byte extremes as label data.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    // Leading dot, two dots in a row, trailing dot before the end item.
    send_item(DOT_CHAR, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(DOT_CHAR, 1'b0);
    send_item(DOT_CHAR, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(DOT_CHAR, 1'b0);
    send_item(8'h00, 1'b1);
    // Neighbors of the dot value are ordinary characters.
    send_item(8'h2D, 1'b0);
    send_item(8'h2F, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(DOT_CHAR, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h01, 1'b1);
    send_item(8'h7A, 1'b0);
    send_item(8'h2E, 1'b1);

    base     = items_sent;
    name_idx = 0;
    while (items_sent < base + RAND_ITEMS) begin
      if (!drain_done && items_sent >= base + RAND_ITEMS / 2) begin
        drain_done = 1'b1;
        wait_drained();
      end
      if (name_idx == 0) begin
        // Label of exactly the maximum length.
        send_label(LBL_MAX);
        send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
      end else if (name_idx == 1) begin
        // Over-long label, then a short one; the flag must show on this terminator only.
        send_label(LBL_MAX + 4);
        send_item(DOT_CHAR, 1'b0);
        send_label(3);
        send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
      end else if ($urandom_range(0, 99) < 85) begin
        nlab = $urandom_range(1, 4);
        for (int l = 0; l < nlab; l++) begin
          if (l > 0) send_item(DOT_CHAR, 1'b0);
          send_label(pick_label_len());
        end
        if ($urandom_range(0, 9) == 0) send_item(DOT_CHAR, 1'b0);
        send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
      end else begin
        // Noise: loose characters and dots, sometimes an end item.
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) == 0)
            send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
          else if ($urandom_range(0, 9) < 3)
            send_item(DOT_CHAR, 1'b0);
          else
            send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
        end
      end
      name_idx++;
    end
    // Close whatever label the noise may have left open.
    send_item(8'h00, 1'b1);
    @(negedge clk);
    in_valid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Encoded %0d names from %0d input transfers; %0d output bytes checked.",
             sb.names_done, sb.inputs_seen, sb.results_seen);
    $display("%0d names had an over-long label, longest label offered %0d characters.",
             sb.long_names, sb.longest_label);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d bytes never arrived", sb.mismatches, sb.pending());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dnle_pkg.sv
hdl/dnle_ram.sv
hdl/dnle_ctrl.sv
hdl/dns_name_label_encoder_unit.sv
tb/tb_top.sv
